/* hdl/chte_pkg.sv */
package chte_pkg;

   // configuration register indexes
   localparam logic CSR_BUCKET_COUNT = 1'b0;
   localparam logic CSR_LOAD_LIMIT   = 1'b1;

   localparam int REG_W = 11;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_UPDATE = 2'd2,
      OP_REMOVE = 2'd3
   } chte_op_type;

   typedef enum logic [1:0] {
      STS_DONE     = 2'd0,
      STS_NOTFOUND = 2'd1,
      STS_FULL     = 2'd2
   } chte_status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_MIX,
      ST_DIV,
      ST_INS_RD,
      ST_INS_WR,
      ST_HEAD_RD,
      ST_HEAD_LD,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_RM_FREE,
      ST_DONE
   } chte_state_type;

endpackage

/* hdl/chte_ram.sv */
module chte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hdl/chained_hash_table_engine_core.sv */
// insert steps from accept to result: mix, modulo (4 bits a cycle), free-list read, chain write, result
// a refused insert skips the free-list read and write; a search, update or remove reads the bucket head,
// then walks the chain to a search or remove match or to its end; a remove hit also frees the entry
// one transaction at a time; a new one is accepted while the last result waits on the output
// reset starts a clearing pass over the head and link memories,
// during which no transaction is accepted; configuration writes are taken throughout
module chained_hash_table_engine_core import chte_pkg::*; #(
   parameter int BUCKETS = 1024,
   parameter int ENTRIES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_lookup_key,
   input  logic signed [31:0] req_data_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [10:0]        rsp_live_entries,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [REG_W-1:0]   csr_wdata
);

   localparam int EW = $clog2(ENTRIES + 1);
   localparam int AW = $clog2(ENTRIES);
   localparam int BW = $clog2(BUCKETS);
   localparam int IL = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
   localparam int IW = $clog2(IL);
   localparam logic [31:0] BUCKETS_W = BUCKETS;
   localparam logic [31:0] ENTRIES_W = ENTRIES;
   localparam logic [31:0] IL_LAST   = IL - 1;

   chte_state_type    state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [31:0]       key_ff, key_in;
   logic [31:0]       val_ff, val_in;
   logic [31:0]       hash_ff, hash_in;
   logic [31:0]       div_ff, div_in;
   logic [REG_W-1:0]  rem_ff, rem_in;
   logic [REG_W-1:0]  den_ff, den_in;
   logic [2:0]        dcnt_ff, dcnt_in;
   logic [BW-1:0]     bucket_ff, bucket_in;
   logic [EW-1:0]     cur_ff, cur_in;
   logic [EW-1:0]     prev_ff, prev_in;
   logic [EW-1:0]     steps_ff, steps_in;
   logic              found_ff, found_in;
   logic [31:0]       rd_ff, rd_in;
   logic [1:0]        st_ff, st_in;
   logic [EW-1:0]     free_ff, free_in;
   logic [REG_W-1:0]  count_ff, count_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [REG_W-1:0]  bcount_ff, llimit_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_rd_ff, rsp_rd_in;
   logic [1:0]        rsp_st_ff, rsp_st_in;
   logic [REG_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // memory ports
   logic          head_we, link_we, data_we;
   logic [BW-1:0] head_waddr, head_raddr;
   logic [EW-1:0] head_wdata, head_rdata;
   logic [AW-1:0] link_waddr, link_raddr, data_waddr, data_raddr;
   logic [EW-1:0] link_wdata, link_rdata;
   logic          value_we;
   logic [31:0]   hash_rdata, key_rdata, value_rdata, value_wdata;

   logic          accept, rsp_load, cur_ok, free_ok, match, is_full, init_last;
   logic [31:0]   mix_word, idx_plus;
   logic [REG_W:0] count_plus;
   logic [AW-1:0] cur_addr, free_addr, prev_addr;

   function automatic logic [31:0] mix_key(input logic [31:0] k);
      logic [31:0] h;
      h = k;
      h = h + ~(h << 9);
      h = h ^ ((h >> 14) | (h << 18));
      h = h + (h << 4);
      h = h ^ ((h >> 10) | (h << 22));
      return h;
   endfunction

   function automatic logic [AW-1:0] ent_addr(input logic [EW-1:0] e);
      logic [EW-1:0] t;
      t = e - EW'(1);
      return t[AW-1:0];
   endfunction

   // memories
   chte_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_heads (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata));
   chte_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_links (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(link_raddr), .rdata(link_rdata));
   chte_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_hashes (
      .clock(clock), .we(data_we), .waddr(data_waddr), .wdata(hash_ff),
      .raddr(data_raddr), .rdata(hash_rdata));
   chte_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_keys (
      .clock(clock), .we(data_we), .waddr(data_waddr), .wdata(key_ff),
      .raddr(data_raddr), .rdata(key_rdata));
   chte_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_values (
      .clock(clock), .we(value_we), .waddr(data_waddr), .wdata(value_wdata),
      .raddr(data_raddr), .rdata(value_rdata));

   // handshake and common terms
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign cur_ok    = (cur_ff != '0) && ({{(32-EW){1'b0}}, cur_ff} <= ENTRIES_W);
   assign free_ok   = (free_ff != '0) && ({{(32-EW){1'b0}}, free_ff} <= ENTRIES_W);
   assign match     = (hash_rdata == hash_ff) && (key_rdata == key_ff);
   assign count_plus = {1'b0, count_ff} + (REG_W+1)'(1);
   assign is_full   = (count_plus > {1'b0, llimit_ff}) || !free_ok;
   assign init_last = ({{(32-IW){1'b0}}, idx_ff} == IL_LAST);
   assign mix_word  = mix_key(key_ff);
   assign idx_plus  = {{(32-IW){1'b0}}, idx_ff} + 32'd2;
   assign cur_addr  = ent_addr(cur_ff);
   assign free_addr = ent_addr(free_ff);
   assign prev_addr = ent_addr(prev_ff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_rd_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_live_entries = rsp_cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX:     state_in = ST_DIV;
         ST_DIV: begin
            if (dcnt_ff == 3'd7) begin
               if (op_ff == OP_INSERT) begin
                  state_in = is_full ? ST_DONE : ST_INS_RD;
               end else begin
                  state_in = ST_HEAD_RD;
               end
            end
         end
         ST_INS_RD:  state_in = ST_INS_WR;
         ST_INS_WR:  state_in = ST_DONE;
         ST_HEAD_RD: state_in = ST_HEAD_LD;
         ST_HEAD_LD: state_in = ST_WALK_RD;
         ST_WALK_RD: begin
            if (!cur_ok || ({{(32-EW){1'b0}}, steps_ff} == ENTRIES_W)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (match && op_ff == OP_SEARCH) begin
               state_in = ST_DONE;
            end else if (match && op_ff == OP_REMOVE) begin
               state_in = ST_RM_FREE;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_RM_FREE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_INIT;
      endcase
   end

   // datapath and memory control
   always_comb begin
      logic [REG_W-1:0] r;
      logic [REG_W:0]   t;
      logic [31:0]      d;
      logic [REG_W+BW-1:0] bwide;

      op_in     = op_ff;
      key_in    = key_ff;
      val_in    = val_ff;
      hash_in   = hash_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      dcnt_in   = dcnt_ff;
      bucket_in = bucket_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      steps_in  = steps_ff;
      found_in  = found_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      free_in   = free_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;

      head_we     = 1'b0;
      head_waddr  = bucket_ff;
      head_wdata  = '0;
      head_raddr  = bucket_ff;
      link_we     = 1'b0;
      link_waddr  = cur_addr;
      link_wdata  = '0;
      link_raddr  = cur_addr;
      data_we     = 1'b0;
      value_we    = 1'b0;
      data_waddr  = cur_addr;
      data_raddr  = cur_addr;
      value_wdata = val_ff;

      // four restoring divide steps for the bucket modulo
      r = rem_ff;
      d = div_ff;
      for (int i = 0; i < 4; i++) begin
         t = {r, d[31]};
         d = {d[30:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t = t - {1'b0, den_ff};
         end
         r = t[REG_W-1:0];
      end
      bwide = {{BW{1'b0}}, r};

      case (state_ff)
         // clearing pass over heads, links threaded into the free list
         ST_INIT: begin
            idx_in = idx_ff + IW'(1);
            if ({{(32-IW){1'b0}}, idx_ff} < BUCKETS_W) begin
               head_we    = 1'b1;
               head_waddr = idx_ff[BW-1:0];
            end
            if ({{(32-IW){1'b0}}, idx_ff} < ENTRIES_W) begin
               link_we    = 1'b1;
               link_waddr = idx_ff[AW-1:0];
               link_wdata = ({{(32-IW){1'b0}}, idx_ff} == ENTRIES_W - 32'd1) ?
                            '0 : idx_plus[EW-1:0];
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               key_in   = req_lookup_key;
               val_in   = req_data_value;
               rd_in    = '0;
               st_in    = STS_DONE;
               found_in = 1'b0;
               prev_in  = '0;
               steps_in = '0;
            end
         end
         // hash and divisor setup
         ST_MIX: begin
            hash_in = mix_word;
            div_in  = mix_word;
            rem_in  = '0;
            dcnt_in = '0;
            if (bcount_ff == '0) begin
               den_in = REG_W'(1);
            end else if ({{(32-REG_W){1'b0}}, bcount_ff} > BUCKETS_W) begin
               den_in = BUCKETS_W[REG_W-1:0];
            end else begin
               den_in = bcount_ff;
            end
         end
         ST_DIV: begin
            div_in    = d;
            rem_in    = r;
            dcnt_in   = dcnt_ff + 3'd1;
            bucket_in = bwide[BW-1:0];
            if (dcnt_ff == 3'd7 && op_ff == OP_INSERT && is_full) begin
               st_in = STS_FULL;
            end
         end
         // insert: pop free list, push at chain head
         ST_INS_RD: begin
            link_raddr = free_addr;
         end
         ST_INS_WR: begin
            free_in    = link_rdata;
            count_in   = count_ff + REG_W'(1);
            data_we    = 1'b1;
            value_we   = 1'b1;
            data_waddr = free_addr;
            link_we    = 1'b1;
            link_waddr = free_addr;
            link_wdata = head_rdata;
            head_we    = 1'b1;
            head_wdata = free_ff;
         end
         ST_HEAD_LD: begin
            cur_in = head_rdata;
         end
         ST_WALK_RD: begin
            if (!cur_ok || ({{(32-EW){1'b0}}, steps_ff} == ENTRIES_W)) begin
               st_in = found_ff ? STS_DONE : STS_NOTFOUND;
            end
         end
         // compare one chain entry
         ST_WALK_CHK: begin
            if (match && op_ff == OP_SEARCH) begin
               rd_in = value_rdata;
            end else if (match && op_ff == OP_REMOVE) begin
               rd_in  = value_rdata;
               if (prev_ff != '0) begin
                  link_we    = 1'b1;
                  link_waddr = prev_addr;
                  link_wdata = link_rdata;
               end else begin
                  head_we    = 1'b1;
                  head_wdata = link_rdata;
               end
            end else begin
               if (match) begin
                  value_we = 1'b1;
                  found_in = 1'b1;
               end
               prev_in  = cur_ff;
               cur_in   = link_rdata;
               steps_in = steps_ff + EW'(1);
            end
         end
         // give removed entry back to the free list
         ST_RM_FREE: begin
            link_we    = 1'b1;
            link_wdata = free_ff;
            free_in    = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - REG_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rd_in    = rsp_rd_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_rd_in    = rd_ff;
         rsp_st_in    = st_ff;
         rsp_cnt_in   = count_ff;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         free_ff      <= EW'(1);
         count_ff     <= '0;
         bcount_ff    <= REG_W'(769);
         llimit_ff    <= REG_W'(500);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && csr_index == CSR_BUCKET_COUNT) begin
            bcount_ff <= csr_wdata;
         end
         if (csr_write_enable && csr_index == CSR_LOAD_LIMIT) begin
            llimit_ff <= csr_wdata;
         end
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      hash_ff    <= hash_in;
      div_ff     <= div_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      dcnt_ff    <= dcnt_in;
      bucket_ff  <= bucket_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      steps_ff   <= steps_in;
      found_ff   <= found_in;
      rd_ff      <= rd_in;
      st_ff      <= st_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

endmodule
